// File: rtl/core/jor_pkg.sv
`default_nettype none

package jor_pkg;

    // Field widths of one stream item
    localparam int PT_W   = 16;
    localparam int ETA_W  = 11;
    localparam int PHI_W  = 10;
    localparam int FUNC_W = 2;
    localparam int DIST_W = 23;
    localparam int OUT_IDX_W = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 23;

    // Item kinds on the input stream
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MATCH  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_JET_PT_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DR_MAX_SQ  = 2'd1;

    // One stored jet, pt in the lowest bits as on the input stream
    typedef struct packed {
        logic [PHI_W-1:0]        phi;
        logic signed [ETA_W-1:0] eta;
        logic [PT_W-1:0]         pt;
    } jet_entry_t;

endpackage

`default_nettype wire

// File: rtl/core/jor_dist.sv
`default_nettype none

module jor_dist
    import jor_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic signed [ETA_W-1:0] a_eta,
    input  wire logic [PHI_W-1:0]        a_phi,
    input  wire logic signed [ETA_W-1:0] b_eta,
    input  wire logic [PHI_W-1:0]        b_phi,
    output logic [DIST_W-1:0]            dist_sq
);

    logic signed [ETA_W:0]     deta;
    logic signed [PHI_W-1:0]   dphi;
    logic signed [2*ETA_W+1:0] eta_prod;
    logic signed [2*PHI_W-1:0] phi_prod;
    logic [2*ETA_W-1:0]        eta_sq_reg;
    logic [2*PHI_W-2:0]        phi_sq_reg;

    // Differences: eta exact, phi wrapped into one half turn either way
    assign deta     = $signed({a_eta[ETA_W-1], a_eta}) - $signed({b_eta[ETA_W-1], b_eta});
    assign dphi     = $signed(a_phi - b_phi);
    assign eta_prod = deta * deta;
    assign phi_prod = dphi * dphi;

    // Register the squares
    always_ff @(posedge clk)
    begin
        eta_sq_reg <= eta_prod[2*ETA_W-1:0];
        phi_sq_reg <= phi_prod[2*PHI_W-2:0];
    end

    // Sum of squares fits the distance width
    assign dist_sq = DIST_W'(eta_sq_reg) + DIST_W'(phi_sq_reg);

endmodule

`default_nettype wire

// File: rtl/core/jet_overlap_removal.sv
`default_nettype none

// Channel   Dir  Handshake                  Payload
// s_*       in   s_tvalid / s_tready        s_tdata item fields, s_tuser item kind
// m_*       out  m_tvalid / m_tready        m_tdata surviving jet, m_tlast, m_tuser
// cfg_*     in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A match issues one memory read a cycle through a two-stage distance pipeline, then a
// write of the removed flag. A finish reads each surviving jet into the output register,
// waiting under output stalls; the single memory read port sets both scans.
// Reset clears the jet count, removed flags and overflow flag; the jet memory is
// not cleared. Configuration writes are taken in any cycle.

module jet_overlap_removal
    import jor_pkg::*;
#(
    parameter int MAX_JETS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // s_tdata: obj_pt[15:0], obj_eta[26:16], obj_phi[36:27], zero[39:37]
    input  wire logic [39:0]           s_tdata,
    // s_tuser: func[1:0]
    input  wire logic [FUNC_W-1:0]     s_tuser,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // m_tdata: jet_pos[5:0], jet_pt[21:6], jet_eta[32:22], jet_phi[42:33], zero[47:43]
    output logic [47:0]                m_tdata,
    // m_tuser: overflow[0]
    output logic                       m_tuser,
    output logic                       m_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready
);

    localparam int IDX_W = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1;
    localparam int CNT_W = $clog2(MAX_JETS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_EMIT = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // Jet store
    jet_entry_t jet_mem [MAX_JETS];
    jet_entry_t rd_data_reg;
    logic       rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic       wr_en;
    logic [IDX_W-1:0] wr_addr;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic                lost_reg, lost_next;
    logic [MAX_JETS-1:0] removed_reg, removed_next;
    logic [PT_W-1:0]     pt_min_reg, pt_min_next;
    logic [DIST_W-1:0]   dr_max_reg, dr_max_next;
    logic signed [ETA_W-1:0] obj_eta_reg, obj_eta_next;
    logic [PHI_W-1:0]    obj_phi_reg, obj_phi_next;

    logic                found_reg, found_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [DIST_W-1:0]   best_d_reg, best_d_next;
    logic                p1_valid_reg, p1_valid_next;
    logic [IDX_W-1:0]    p1_idx_reg, p1_idx_next;
    logic                p1_rm_reg, p1_rm_next;
    logic                p2_valid_reg, p2_valid_next;
    logic [IDX_W-1:0]    p2_idx_reg, p2_idx_next;
    logic                p2_rm_reg, p2_rm_next;

    logic                m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]    out_idx_reg, out_idx_next;
    jet_entry_t          out_entry_reg, out_entry_next;
    logic                out_last_reg, out_last_next;
    logic                out_ovf_reg, out_ovf_next;

    jet_entry_t          in_entry;
    logic [FUNC_W-1:0]   in_func;
    logic                in_xfer;
    logic                out_xfer;
    logic [DIST_W-1:0]   dist_sq;
    logic [MAX_JETS-1:0] later_live;

    assign in_entry  = jet_entry_t'(s_tdata[PT_W+ETA_W+PHI_W-1:0]);
    assign in_func   = s_tuser;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = m_valid_reg && m_tready;
    assign cfg_ready = 1'b1;

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            jet_mem[wr_addr] <= in_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= jet_mem[rd_addr];
        end
    end

    // Squared distance of the pending object to the jet just read
    jor_dist u_dist (
        .clk     (clk),
        .a_eta   (obj_eta_reg),
        .a_phi   (obj_phi_reg),
        .b_eta   (rd_data_reg.eta),
        .b_phi   (rd_data_reg.phi),
        .dist_sq (dist_sq)
    );

    // Live jets loaded after the emit pointer
    always_comb
    begin
        for (int k = 0; k < MAX_JETS; k++)
        begin
            later_live[k] = !removed_reg[k] && (CNT_W'(k) < cnt_reg) && (CNT_W'(k) > ptr_reg);
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        lost_next      = lost_reg;
        removed_next   = removed_reg;
        pt_min_next    = pt_min_reg;
        dr_max_next    = dr_max_reg;
        obj_eta_next   = obj_eta_reg;
        obj_phi_next   = obj_phi_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_d_next    = best_d_reg;
        p1_valid_next  = 1'b0;
        p1_idx_next    = p1_idx_reg;
        p1_rm_next     = p1_rm_reg;
        p2_valid_next  = p1_valid_reg;
        p2_idx_next    = p1_idx_reg;
        p2_rm_next     = p1_rm_reg;
        m_valid_next   = m_valid_reg;
        out_idx_next   = out_idx_reg;
        out_entry_next = out_entry_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = cnt_reg[IDX_W-1:0];

        // Configuration writes
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_JET_PT_MIN: pt_min_next = cfg_data[PT_W-1:0];
                REG_DR_MAX_SQ:  dr_max_next = cfg_data;
                default:        ;
            endcase
        end

        // Track the closest live jet in range
        if (p2_valid_reg && !p2_rm_reg && (dist_sq <= dr_max_reg)
            && (!found_reg || (dist_sq < best_d_reg)))
        begin
            found_next    = 1'b1;
            best_idx_next = p2_idx_reg;
            best_d_next   = dist_sq;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (in_func)
                        FUNC_LOAD:
                        begin
                            if (cnt_reg < CNT_W'(MAX_JETS))
                            begin
                                wr_en = 1'b1;
                                removed_next[wr_addr] = (in_entry.pt < pt_min_reg);
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                            else
                            begin
                                lost_next = 1'b1;
                            end
                        end
                        FUNC_MATCH:
                        begin
                            if (in_entry.pt != '0)
                            begin
                                obj_eta_next = in_entry.eta;
                                obj_phi_next = in_entry.phi;
                                found_next   = 1'b0;
                                ptr_next     = '0;
                                state_next   = ST_SCAN;
                            end
                        end
                        FUNC_FINISH:
                        begin
                            ptr_next   = '0;
                            state_next = ST_EMIT;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (ptr_reg < cnt_reg)
                begin
                    // Issue one read a cycle
                    rd_en         = 1'b1;
                    p1_valid_next = 1'b1;
                    p1_idx_next   = rd_addr;
                    p1_rm_next    = removed_reg[rd_addr];
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
                else if (!p1_valid_reg && !p2_valid_reg)
                begin
                    // Pipeline drained: mark the winner
                    if (found_reg)
                    begin
                        removed_next[best_idx_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (ptr_reg >= cnt_reg)
                begin
                    // Drop the event
                    removed_next = '0;
                    cnt_next     = '0;
                    lost_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
                else if (removed_reg[rd_addr])
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                // Load the output register
                m_valid_next   = 1'b1;
                out_idx_next   = ptr_reg[IDX_W-1:0];
                out_entry_next = rd_data_reg;
                out_last_next  = ~|later_live;
                out_ovf_next   = lost_reg;
                state_next     = ST_OUT;
            end

            ST_OUT:
            begin
                if (out_xfer)
                begin
                    m_valid_next = 1'b0;
                    ptr_next     = ptr_reg + CNT_W'(1);
                    state_next   = ST_EMIT;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            lost_reg      <= 1'b0;
            removed_reg   <= '0;
            pt_min_reg    <= '0;
            dr_max_reg    <= '0;
            found_reg     <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            lost_reg      <= lost_next;
            removed_reg   <= removed_next;
            pt_min_reg    <= pt_min_next;
            dr_max_reg    <= dr_max_next;
            found_reg     <= found_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        obj_eta_reg   <= obj_eta_next;
        obj_phi_reg   <= obj_phi_next;
        best_idx_reg  <= best_idx_next;
        best_d_reg    <= best_d_next;
        p1_idx_reg    <= p1_idx_next;
        p1_rm_reg     <= p1_rm_next;
        p2_idx_reg    <= p2_idx_next;
        p2_rm_reg     <= p2_rm_next;
        out_idx_reg   <= out_idx_next;
        out_entry_reg <= out_entry_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // Output stream
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, out_entry_reg.phi, out_entry_reg.eta, out_entry_reg.pt,
                       OUT_IDX_W'(out_idx_reg)};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import jor_pkg::*;

    localparam int JET_CAP       = 32;
    localparam int ITEM_TARGET   = 410;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 2 * JET_CAP + 16;
    localparam int QUIET_LIMIT   = 4000;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [CFG_DATA_W-1:0] DR_SQ_MAX = '1;
    localparam logic [PT_W-1:0] PT_MAX = '1;
    localparam logic signed [ETA_W-1:0] ETA_MIN = {1'b1, {(ETA_W-1){1'b0}}};

    // One surviving jet as it should leave the block
    typedef struct {
        logic [OUT_IDX_W-1:0]    idx;
        logic [PT_W-1:0]         pt;
        logic signed [ETA_W-1:0] eta;
        logic [PHI_W-1:0]        phi;
        logic                    is_last;
        logic                    ovf;
    } survivor_t;

    logic clk = 1'b0;
    logic rst_n;

    logic [39:0]           s_tdata;
    logic [FUNC_W-1:0]     s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [47:0]           m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  cfg_valid;
    logic                  cfg_ready;

    // Jet store as the block should hold it
    jet_entry_t         jet_store[JET_CAP];
    bit                 jet_gone[JET_CAP];
    int                 jet_cnt = 0;
    bit                 jets_lost = 1'b0;
    logic [PT_W-1:0]    cut_pt_min = '0;
    logic [DIST_W-1:0]  cut_dr_sq = '0;

    survivor_t survivors_due[$];
    int        mismatches = 0;
    int        live_items = 0;
    bit        steady = 1'b0;
    bit        hold_req = 1'b0;
    int        quiet_cycles = 0;

    // Positions loaded in the current random event
    logic signed [ETA_W-1:0] evt_eta[JET_CAP + 8];
    logic [PHI_W-1:0]        evt_phi[JET_CAP + 8];

    jet_overlap_removal #(
        .MAX_JETS (JET_CAP)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always #10 clk = ~clk;

    // Squared eta-phi distance, phi difference wrapped into -512..511
    function automatic int unsigned dr_sq(logic signed [ETA_W-1:0] ea, logic [PHI_W-1:0] pa,
                                          logic signed [ETA_W-1:0] eb, logic [PHI_W-1:0] pb);
        int             de;
        int             dp;
        logic [PHI_W-1:0] wrap;
        de = int'(ea) - int'(eb);
        wrap = pa - pb;
        dp = int'(wrap);
        if (dp >= 512)
            dp -= 1024;
        return de * de + dp * dp;
    endfunction

    // Advance the jet store by one accepted item, queue the survivors on finish
    function automatic void update_jet_store(logic [FUNC_W-1:0] fn, logic [PT_W-1:0] pt,
                                             logic signed [ETA_W-1:0] eta,
                                             logic [PHI_W-1:0] phi);
        int          best;
        int unsigned best_d;
        int unsigned d;
        int          last_j;
        survivor_t   r;
        case (fn)
            FUNC_LOAD:
            begin
                live_items++;
                if (jet_cnt < JET_CAP)
                begin
                    jet_store[jet_cnt].pt  = pt;
                    jet_store[jet_cnt].eta = eta;
                    jet_store[jet_cnt].phi = phi;
                    jet_gone[jet_cnt] = (pt < cut_pt_min);
                    jet_cnt++;
                end
                else
                    jets_lost = 1'b1;
            end
            FUNC_MATCH:
            begin
                if (pt != '0)
                begin
                    live_items++;
                    best = -1;
                    best_d = 0;
                    for (int j = 0; j < jet_cnt; j++)
                    begin
                        if (jet_gone[j])
                            continue;
                        d = dr_sq(eta, phi, jet_store[j].eta, jet_store[j].phi);
                        if (d > cut_dr_sq)
                            continue;
                        if (best < 0 || d < best_d)
                        begin
                            best = j;
                            best_d = d;
                        end
                    end
                    if (best >= 0)
                        jet_gone[best] = 1'b1;
                end
            end
            FUNC_FINISH:
            begin
                live_items++;
                last_j = -1;
                for (int j = 0; j < jet_cnt; j++)
                    if (!jet_gone[j])
                        last_j = j;
                for (int j = 0; j < jet_cnt; j++)
                begin
                    if (jet_gone[j])
                        continue;
                    r.idx     = OUT_IDX_W'(j);
                    r.pt      = jet_store[j].pt;
                    r.eta     = jet_store[j].eta;
                    r.phi     = jet_store[j].phi;
                    r.is_last = (j == last_j);
                    r.ovf     = jets_lost;
                    survivors_due.insert(survivors_due.size(), r);
                end
                for (int j = 0; j < JET_CAP; j++)
                    jet_gone[j] = 1'b0;
                jet_cnt = 0;
                jets_lost = 1'b0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offer one item, hold it until the transfer, then predict
    task automatic push_item(input logic [FUNC_W-1:0] fn, input logic [PT_W-1:0] pt,
                             input logic signed [ETA_W-1:0] eta, input logic [PHI_W-1:0] phi);
        while (!steady && $urandom_range(99) < 19)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= {3'b000, phi, eta, pt};
        s_tuser  <= fn;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        update_jet_store(fn, pt, eta, phi);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_JET_PT_MIN: cut_pt_min = val[PT_W-1:0];
            REG_DR_MAX_SQ:  cut_dr_sq = val;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stop offering, wait for every survivor, then let a match scan finish
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (survivors_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Match near a jet of the current event, or anywhere now and then
    task automatic push_match_near(input int n_loaded);
        int                      pick;
        int                      off;
        int                      de;
        int                      dp;
        logic [PT_W-1:0]         pt;
        logic signed [ETA_W-1:0] eta;
        logic [PHI_W-1:0]        phi;
        pt = ($urandom_range(9) == 0) ? '0 : PT_W'($urandom_range(1, 65535));
        if (n_loaded == 0 || $urandom_range(4) == 0)
        begin
            eta = ETA_W'($urandom);
            phi = PHI_W'($urandom);
        end
        else
        begin
            pick = $urandom_range(0, n_loaded - 1);
            off = $urandom_range(0, 8);
            de = $urandom_range(0, 2 * off);
            dp = $urandom_range(0, 2 * off);
            de = int'(evt_eta[pick]) + de - off;
            if (de > 1023)
                de = 1023;
            if (de < -1024)
                de = -1024;
            eta = ETA_W'(de);
            phi = evt_phi[pick] + PHI_W'(dp - off);
        end
        push_item(FUNC_MATCH, pt, eta, phi);
    endtask

    // One event: jets with matches in between, more matches, some noise, finish
    task automatic run_event();
        int              sel;
        int              n_jets;
        int              n_match;
        int              c;
        logic [PT_W-1:0] pt;
        sel = $urandom_range(99);
        if (sel < 5)
            n_jets = 0;
        else if (sel < 15)
            n_jets = $urandom_range(20, JET_CAP + 4);
        else
            n_jets = $urandom_range(1, 8);
        for (int k = 0; k < n_jets; k++)
        begin
            // Duplicate a position now and then to force equal distances
            if (k > 0 && $urandom_range(9) == 0)
            begin
                evt_eta[k] = evt_eta[k - 1];
                evt_phi[k] = evt_phi[k - 1];
            end
            else
            begin
                evt_eta[k] = ETA_W'($urandom);
                evt_phi[k] = PHI_W'($urandom);
            end
            case ($urandom_range(9)) inside
                0: pt = '0;
                [1:3]:
                begin
                    c = int'(cut_pt_min) + int'($urandom_range(0, 2)) - 1;
                    if (c < 0)
                        c = 0;
                    if (c > 65535)
                        c = 65535;
                    pt = PT_W'(c);
                end
                default: pt = PT_W'($urandom);
            endcase
            push_item(FUNC_LOAD, pt, evt_eta[k], evt_phi[k]);
            if ($urandom_range(3) == 0)
                push_match_near(k + 1);
        end
        n_match = $urandom_range(0, n_jets + 1);
        for (int k = 0; k < n_match; k++)
            push_match_near(n_jets);
        if ($urandom_range(9) == 0)
            push_item(FUNC_UNUSED, PT_W'($urandom), ETA_W'($urandom), PHI_W'($urandom));
        push_item(FUNC_FINISH, PT_W'($urandom), ETA_W'($urandom), PHI_W'($urandom));
    endtask

    task automatic test_directed();
        // Reset settings: no pt cut, only exact hits count
        push_item(FUNC_LOAD, '0, 11'sd0, 10'd0);
        push_item(FUNC_LOAD, PT_MAX, ETA_MIN, 10'd1023);
        push_item(FUNC_LOAD, 16'd1, 11'sd1023, 10'd0);
        push_item(FUNC_MATCH, '0, ETA_MIN, 10'd1023);
        push_item(FUNC_MATCH, PT_MAX, ETA_MIN, 10'd1023);
        push_item(FUNC_MATCH, 16'd5, 11'sd1023, 10'd1);
        push_item(FUNC_UNUSED, PT_MAX, 11'sd0, 10'd0);
        push_item(FUNC_FINISH, '0, 11'sd0, 10'd0);
        drain_block();
        write_reg(REG_JET_PT_MIN, 23'd100);
        write_reg(REG_DR_MAX_SQ, DR_SQ_MAX);
        write_reg(REG_SPARE, DR_SQ_MAX);
        // Threshold edge, early match, tie on equal distance, phi wrap
        push_item(FUNC_LOAD, 16'd99, 11'sd10, 10'd5);
        push_item(FUNC_LOAD, 16'd100, 11'sd10, 10'd5);
        push_item(FUNC_MATCH, 16'd200, 11'sd500, 10'd512);
        push_item(FUNC_LOAD, 16'd300, 11'sd20, 10'd1020);
        push_item(FUNC_LOAD, 16'd300, 11'sd20, 10'd1020);
        push_item(FUNC_MATCH, 16'd7, 11'sd20, 10'd4);
        push_item(FUNC_LOAD, PT_MAX, ETA_MIN, 10'd0);
        push_item(FUNC_MATCH, 16'd1, 11'sd1023, 10'd512);
        push_item(FUNC_FINISH, '0, 11'sd0, 10'd0);
        // Empty store, then a store whose only jet fails the cut
        push_item(FUNC_FINISH, PT_MAX, -11'sd1, 10'd1023);
        push_item(FUNC_LOAD, '0, 11'sd0, 10'd0);
        push_item(FUNC_FINISH, '0, 11'sd0, 10'd0);
        drain_block();
    endtask

    task automatic test_backpressure();
        write_reg(REG_JET_PT_MIN, '0);
        write_reg(REG_DR_MAX_SQ, '0);
        // Stall the output while two full events keep coming
        hold_req = 1'b1;
        for (int e = 0; e < 2; e++)
        begin
            for (int k = 0; k < JET_CAP; k++)
                push_item(FUNC_LOAD, PT_W'($urandom), ETA_W'($urandom), PHI_W'($urandom));
            push_item(FUNC_FINISH, '0, 11'sd0, 10'd0);
        end
        drain_block();
    endtask

    task automatic test_random_phases();
        int phase;
        phase = 0;
        while (live_items < ITEM_TARGET)
        begin
            steady = (phase % 5 == 3);
            case (phase % 5)
                0:
                begin
                    write_reg(REG_JET_PT_MIN, 23'(PT_MAX));
                    write_reg(REG_DR_MAX_SQ, DR_SQ_MAX);
                end
                1:
                begin
                    write_reg(REG_JET_PT_MIN, '0);
                    write_reg(REG_DR_MAX_SQ, '0);
                end
                2:
                begin
                    write_reg(REG_JET_PT_MIN, CFG_DATA_W'($urandom_range(0, 65535)));
                    write_reg(REG_DR_MAX_SQ, CFG_DATA_W'($urandom_range(0, 200)));
                end
                3:
                begin
                    write_reg(REG_JET_PT_MIN, CFG_DATA_W'($urandom_range(0, 4000)));
                    write_reg(REG_DR_MAX_SQ, CFG_DATA_W'($urandom_range(0, 5000)));
                end
                default:
                begin
                    write_reg(REG_JET_PT_MIN, CFG_DATA_W'($urandom));
                    write_reg(REG_DR_MAX_SQ, CFG_DATA_W'($urandom));
                end
            endcase
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            for (int e = 0; e < 5; e++)
                run_event();
            drain_block();
            phase++;
        end
        steady = 1'b0;
    endtask

    // Output side: random stalls, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                m_tready <= steady || ($urandom_range(99) >= 19);
        end
    end

    // Compare each transfer with the oldest expected survivor
    always @(posedge clk)
    begin : check_survivors
        survivor_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (survivors_due.size() == 0)
            begin
                $error("unexpected output transfer: jet_pos %0d", m_tdata[5:0]);
                mismatches++;
            end
            else
            begin
                want = survivors_due.pop_front();
                if (m_tdata[5:0] !== want.idx)
                begin
                    $error("jet_pos expected %0d actual %0d", want.idx, m_tdata[5:0]);
                    mismatches++;
                end
                if (m_tdata[21:6] !== want.pt)
                begin
                    $error("jet_pt expected %0d actual %0d", want.pt, m_tdata[21:6]);
                    mismatches++;
                end
                if (m_tdata[32:22] !== want.eta)
                begin
                    $error("jet_eta expected %0d actual %0d", want.eta,
                           $signed(m_tdata[32:22]));
                    mismatches++;
                end
                if (m_tdata[42:33] !== want.phi)
                begin
                    $error("jet_phi expected %0d actual %0d", want.phi, m_tdata[42:33]);
                    mismatches++;
                end
                if (m_tlast !== want.is_last)
                begin
                    $error("last expected %0d actual %0d", want.is_last, m_tlast);
                    mismatches++;
                end
                if (m_tuser !== want.ovf)
                begin
                    $error("overflow expected %0d actual %0d", want.ovf, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // End the run when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_LOAD;
        cfg_valid = 1'b0;
        cfg_index = REG_JET_PT_MIN;
        cfg_data  = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        test_random_phases();
        drain_block();

        if (survivors_due.size() != 0)
        begin
            $error("%0d expected survivors never arrived", survivors_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
